// ===== design/bsde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsde_pkg
// Shared constants, types and codes of the B-spline de Boor evaluator.
// ----------------------------------------------------------------------------
package bsde_pkg;

   localparam int MAX_KNOTS  = 64;
   localparam int MAX_ORDER  = 8;
   localparam int VALUE_BITS = 32;

   localparam int KNOT_AW = $clog2(MAX_KNOTS);
   localparam int CNT_W   = KNOT_AW + 1;
   localparam int ORD_W   = $clog2(MAX_ORDER + 1);
   localparam int SLOT_W  = $clog2(MAX_ORDER);
   localparam int PIDX_W  = $clog2(2 * MAX_ORDER);
   localparam int FETCH_LEN = 2 * MAX_ORDER;

   // x carries one extra bit for the edge nudges; spans and sums grow from it.
   localparam int X_W   = VALUE_BITS + 1;
   localparam int DL_W  = VALUE_BITS + 2;
   localparam int DEN_W = VALUE_BITS + 3;
   localparam int OPA_W = VALUE_BITS + 1;
   localparam int NUM_W = OPA_W + DEN_W;
   localparam int REM_W = DEN_W + 1;
   localparam int DIV_STEPS = NUM_W / 2;
   localparam int DIV_CW = $clog2(DIV_STEPS);

   localparam logic [VALUE_BITS-1:0] ONE_Q16 = VALUE_BITS'(65536);

   localparam logic [1:0] ACT_WRITE_KNOT  = 2'd0;
   localparam logic [1:0] ACT_WRITE_COEF  = 2'd1;
   localparam logic [1:0] ACT_EVAL_SPLINE = 2'd2;
   localparam logic [1:0] ACT_EVAL_BASIS  = 2'd3;

   localparam logic REG_DEGREE = 1'b0;
   localparam logic REG_NUM    = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE,
      S_CHECK,
      S_SCAN,
      S_FETCH,
      S_MUL1,
      S_MUL2,
      S_DSTART,
      S_DWAIT,
      S_ROT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic shift_aj;
      logic shift_dr;
   } cell_ctl_type;

   typedef struct packed {
      logic                  done;
      logic                  sat;
      logic [VALUE_BITS-1:0] quo;
   } div_res_type;

endpackage
`default_nettype wire

// ===== design/bsde_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsde_cell
// One cell of the coefficient chain: holds one blend coefficient and one
// right-hand knot span, each shifted in from the neighboring cell.
// ----------------------------------------------------------------------------
module bsde_cell
   import bsde_pkg::*;
(
   input  wire logic                  clock,
   input  wire cell_ctl_type          ctl,
   input  wire logic [VALUE_BITS-1:0] aj_next,
   input  wire logic [DL_W-1:0]       dr_next,
   output logic [VALUE_BITS-1:0]      aj_q,
   output logic [DL_W-1:0]            dr_q
);

   logic [VALUE_BITS-1:0] aj_ff;
   logic [VALUE_BITS-1:0] aj_in;
   logic [DL_W-1:0]       dr_ff;
   logic [DL_W-1:0]       dr_in;

   assign aj_in = ctl.shift_aj ? aj_next : aj_ff;
   assign dr_in = ctl.shift_dr ? dr_next : dr_ff;

   always_ff @(posedge clock) begin
      aj_ff <= aj_in;
      dr_ff <= dr_in;
   end

   assign aj_q = aj_ff;
   assign dr_q = dr_ff;

endmodule
`default_nettype wire

// ===== design/bsde_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsde_divider
// Signed restoring divider, two quotient bits a cycle, truncating toward
// zero and saturating the quotient to the value range.
// ----------------------------------------------------------------------------
module bsde_divider
   import bsde_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic signed [DEN_W-1:0] den,
   output div_res_type                  res
);

   logic              busy_ff, busy_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  work_ff, work_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  ud_ff;
   logic              neg_ff;
   div_res_type       res_ff, res_in;

   logic [NUM_W-1:0]      lim;
   logic [NUM_W-1:0]      qmag;
   logic [VALUE_BITS-1:0] q32;
   logic                  last;

   always_comb begin
      logic [REM_W-1:0] r;
      logic [NUM_W-1:0] w;
      r = rem_ff;
      w = work_ff;
      for (int s = 0; s < 2; s++) begin
         r = {r[REM_W-2:0], w[NUM_W-1]};
         w = {w[NUM_W-2:0], 1'b0};
         if (r >= {1'b0, ud_ff}) begin
            r = r - {1'b0, ud_ff};
            w[0] = 1'b1;
         end
      end
      rem_in  = r;
      work_in = w;
   end

   assign last = busy_ff && (cnt_ff == DIV_CW'(DIV_STEPS - 1));
   assign busy_in = start ? 1'b1 : (last ? 1'b0 : busy_ff);
   assign cnt_in  = start ? '0 : cnt_ff + 1'b1;

   assign lim  = neg_ff ? (NUM_W'(1) << (VALUE_BITS - 1))
                        : ((NUM_W'(1) << (VALUE_BITS - 1)) - NUM_W'(1));
   assign qmag = (work_in > lim) ? lim : work_in;
   assign q32  = qmag[VALUE_BITS-1:0];

   always_comb begin
      res_in.done = last;
      res_in.sat  = work_in > lim;
      res_in.quo  = neg_ff ? (~q32 + 1'b1) : q32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         res_ff.done <= res_in.done;
      end
      cnt_ff <= cnt_in;
      if (start) begin
         work_ff <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         ud_ff   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         rem_ff  <= '0;
         neg_ff  <= num[NUM_W-1] ^ den[DEN_W-1];
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
      if (last) begin
         res_ff.sat <= res_in.sat;
         res_ff.quo <= res_in.quo;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// ===== design/bspline_deboor_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspline_deboor_evaluator
// Stores knots and coefficients and evaluates a B-spline, or one of its basis
// functions, or a derivative of either, at x by de Boor's method in Q16.16.
// ----------------------------------------------------------------------------
//  channel   ports                          moves
//  req       req_valid / req_stall          action, index, value, order
//  rsp       rsp_valid / rsp_stall          result, outside flag, sat flag
//  csr       psel penable pwrite paddr ...  degree (0x0), coefficient count (0x4)
//
// An evaluation reads the edge knots t[0], t[n+k-1], t[i] and t[i+k], scans
// the knots for the span holding x, fetches the knots and coefficients around
// it, then runs k(k-1)/2 blend steps (two multiplies, then a division on the
// two-bit-a-cycle divider unless the denominator is zero) plus MAX_ORDER-(k-j)
// realign shifts of the coefficient chain after each pass j. Reset is
// synchronous; the tables are undefined until written. A new item is taken as
// soon as the result sits in the output register, even while rsp_stall holds it.
// ----------------------------------------------------------------------------
module bspline_deboor_evaluator
   import bsde_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_action,
   input  wire logic [5:0]                   req_entry_index,
   input  wire logic signed [VALUE_BITS-1:0] req_operand_value,
   input  wire logic [2:0]                   req_derivative_order,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0]      rsp_result_value,
   output logic                              rsp_outside_support,
   output logic                              rsp_saturated,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [2:0]                   paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   // Configuration registers.
   logic [2:0] degree_ff;
   logic [5:0] ncoef_ff;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_DEGREE) ? {29'b0, degree_ff} : {26'b0, ncoef_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 3'd3;
         ncoef_ff  <= 6'd8;
      end else if (csr_wr) begin
         if (paddr[2] == REG_DEGREE) begin
            degree_ff <= pwdata[2:0];
         end else begin
            ncoef_ff <= pwdata[5:0];
         end
      end
   end

   // Derived configuration.
   logic [ORD_W-1:0]   k;
   logic [CNT_W-1:0]   n_lim, n_eff, nk, last_knot;

   assign k         = ORD_W'(degree_ff) + ORD_W'(1);
   assign n_lim     = CNT_W'(MAX_KNOTS) - CNT_W'(k);
   assign n_eff     = (CNT_W'(ncoef_ff) > n_lim) ? n_lim : CNT_W'(ncoef_ff);
   assign nk        = n_eff + CNT_W'(k);
   assign last_knot = nk - CNT_W'(1);

   // State.
   state_type state_ff, state_in;

   logic [1:0]                   act_ff;
   logic [5:0]                   idx_ff;
   logic signed [VALUE_BITS-1:0] v_ff;
   logic [2:0]                   jd_ff;
   logic signed [X_W-1:0]        x_ff;
   logic signed [VALUE_BITS-1:0] t0_ff, tl_ff, ti_ff, tk_ff, prev_ff;
   logic [CNT_W-1:0]             cnt_ff, cntp_ff;
   logic                         vldp_ff;
   logic [KNOT_AW-1:0]           m_ff;
   logic                         found_ff;
   logic                         outside_ff, zero_ff, sat_ff;
   logic [ORD_W-1:0]             j_ff;
   logic [SLOT_W-1:0]            jj_ff;
   logic [ORD_W-1:0]             rot_ff;
   logic signed [NUM_W-1:0]      acc_ff;
   logic signed [DL_W-1:0]       dl_ff [MAX_ORDER];

   logic signed [VALUE_BITS-1:0] knot_mem [MAX_KNOTS];
   logic signed [VALUE_BITS-1:0] coef_mem [MAX_KNOTS];
   logic signed [VALUE_BITS-1:0] knot_rd_ff, coef_rd_ff;

   logic                         rsp_valid_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff;
   logic                         rsp_out_ff, rsp_sat_ff;

   // Chain.
   cell_ctl_type          cell_ctl;
   logic [VALUE_BITS-1:0] aj_q [MAX_ORDER];
   logic [DL_W-1:0]       dr_q [MAX_ORDER];
   logic [VALUE_BITS-1:0] tail_aj;
   logic [DL_W-1:0]       tail_dr;

   for (genvar c = 0; c < MAX_ORDER; c++) begin : g_cell
      logic [VALUE_BITS-1:0] aj_next;
      logic [DL_W-1:0]       dr_next;
      if (c == MAX_ORDER - 1) begin : g_tail
         assign aj_next = tail_aj;
         assign dr_next = tail_dr;
      end else begin : g_mid
         assign aj_next = aj_q[c+1];
         assign dr_next = dr_q[c+1];
      end
      bsde_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .aj_next (aj_next),
         .dr_next (dr_next),
         .aj_q    (aj_q[c]),
         .dr_q    (dr_q[c])
      );
   end

   // Handshake.
   logic req_fire, out_free;
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Edge check.
   logic                  outside_c, hideriv_c;
   logic signed [X_W-1:0] v_x, x_a, x_b;

   assign v_x = X_W'(v_ff);
   always_comb begin
      if (n_eff == '0) begin
         outside_c = 1'b1;
      end else if (act_ff == ACT_EVAL_SPLINE) begin
         outside_c = (v_ff < t0_ff) || (v_ff > tl_ff);
      end else begin
         outside_c = (CNT_W'(idx_ff) >= n_eff) || (v_ff < ti_ff) || (v_ff > tk_ff);
      end
      x_a = (v_ff == t0_ff) ? v_x + X_W'(1) : v_x;
      x_b = (x_a == X_W'(tl_ff)) ? x_a - X_W'(1) : x_a;
   end
   assign hideriv_c = (ORD_W'(jd_ff) >= k);

   // Interval scan.
   logic hit, found_in;
   assign hit = (state_ff == S_SCAN) && vldp_ff && (cntp_ff != '0) &&
                (X_W'(prev_ff) <= x_ff) && (x_ff < X_W'(knot_rd_ff));
   assign found_in = found_ff || hit;

   // Fetch.
   logic [PIDX_W-1:0]      p_i, p_c;
   logic signed [8:0]      cidx;
   logic                   cvalid;
   logic [VALUE_BITS-1:0]  push_aj;
   logic signed [DL_W-1:0] knot_minus_x, x_minus_knot;
   logic [CNT_W-1:0]       dr_addr;

   assign p_i  = cnt_ff[PIDX_W-1:0];
   assign p_c  = cntp_ff[PIDX_W-1:0];
   assign cidx = $signed({3'b0, m_ff}) + 9'sd1 + $signed(9'(p_c)) - $signed(9'(k));
   assign cvalid = !cidx[8] && (cidx[7:0] < 8'(n_eff)) && (ORD_W'(p_c) < k);
   always_comb begin
      if (!cvalid) begin
         push_aj = '0;
      end else if (act_ff == ACT_EVAL_BASIS) begin
         push_aj = (cidx[7:0] == 8'(idx_ff)) ? ONE_Q16 : '0;
      end else begin
         push_aj = coef_rd_ff;
      end
   end
   assign knot_minus_x = DL_W'(knot_rd_ff) - DL_W'(x_ff);
   assign x_minus_knot = DL_W'(x_ff) - DL_W'(knot_rd_ff);
   assign dr_addr = CNT_W'(m_ff) + CNT_W'(1) + CNT_W'(p_i - PIDX_W'(MAX_ORDER));

   // Blend step.
   logic [ORD_W-1:0]         kmj;
   logic                     deriv_pass;
   logic signed [DL_W-1:0]   dl_sel, dr0;
   logic signed [DEN_W-1:0]  den;
   logic signed [OPA_W-1:0]  opa;
   logic signed [DEN_W-1:0]  opb;
   logic signed [NUM_W-1:0]  prod;
   logic                     step_done, pass_end;
   logic [VALUE_BITS-1:0]    step_val;
   div_res_type              div_res;
   logic                     div_start;

   assign kmj        = k - j_ff;
   assign deriv_pass = (j_ff <= ORD_W'(jd_ff));
   assign dl_sel     = dl_ff[kmj[SLOT_W-1:0] - jj_ff];
   assign dr0        = $signed(dr_q[0]);
   assign den        = DEN_W'(dl_sel) + DEN_W'(dr0);
   assign pass_end   = (jj_ff == kmj[SLOT_W-1:0]);

   always_comb begin
      opa = '0;
      opb = '0;
      if (state_ff == S_MUL1) begin
         if (deriv_pass) begin
            opa = OPA_W'($signed(aj_q[1])) - OPA_W'($signed(aj_q[0]));
            opb = DEN_W'({kmj, 16'b0});
         end else begin
            opa = OPA_W'($signed(aj_q[1]));
            opb = DEN_W'(dl_sel);
         end
      end else if (!deriv_pass) begin
         opa = OPA_W'($signed(aj_q[0]));
         opb = DEN_W'(dr0);
      end
   end
   assign prod = opa * opb;

   assign div_start = (state_ff == S_DSTART) && (den != '0);
   assign step_done = ((state_ff == S_DSTART) && (den == '0)) ||
                      ((state_ff == S_DWAIT) && div_res.done);
   assign step_val  = (state_ff == S_DSTART) ? '0 : div_res.quo;

   bsde_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_ff),
      .den   (den),
      .res   (div_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_action == ACT_EVAL_SPLINE ||
                             req_action == ACT_EVAL_BASIS)) begin
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            if (cnt_ff == CNT_W'(4)) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (outside_c || hideriv_c) state_in = S_DONE;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cnt_ff == nk) state_in = found_in ? S_FETCH : S_DONE;
         end
         S_FETCH: begin
            if (cnt_ff == CNT_W'(FETCH_LEN)) begin
               state_in = (k == ORD_W'(1)) ? S_DONE : S_MUL1;
            end
         end
         S_MUL1:   state_in = S_MUL2;
         S_MUL2:   state_in = S_DSTART;
         S_DSTART, S_DWAIT: begin
            if (step_done) state_in = pass_end ? S_ROT : S_MUL1;
            else if (state_ff == S_DSTART) state_in = S_DWAIT;
         end
         S_ROT: begin
            if (rot_ff == ORD_W'(1)) begin
               state_in = (j_ff + ORD_W'(1) == k) ? S_DONE : S_MUL1;
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs: read addresses and chain control.
   logic               issue;
   logic [KNOT_AW-1:0] knot_addr, coef_addr;

   always_comb begin
      issue     = 1'b0;
      knot_addr = '0;
      coef_addr = KNOT_AW'(CNT_W'(m_ff) + CNT_W'(1) + CNT_W'(p_i) - CNT_W'(k));
      cell_ctl  = '0;
      tail_aj   = aj_q[0];
      tail_dr   = dr_q[0];
      case (state_ff)
         S_EDGE: begin
            issue = (cnt_ff < CNT_W'(4));
            case (cnt_ff[1:0])
               2'd0:    knot_addr = '0;
               2'd1:    knot_addr = last_knot[KNOT_AW-1:0];
               2'd2:    knot_addr = idx_ff;
               default: knot_addr = idx_ff + KNOT_AW'(k);
            endcase
         end
         S_SCAN: begin
            issue     = (cnt_ff < nk);
            knot_addr = cnt_ff[KNOT_AW-1:0];
         end
         S_FETCH: begin
            issue = (cnt_ff < CNT_W'(FETCH_LEN));
            if (p_i < PIDX_W'(MAX_ORDER)) begin
               knot_addr = (CNT_W'(m_ff) >= CNT_W'(p_i)) ? m_ff - KNOT_AW'(p_i) : '0;
            end else begin
               knot_addr = (dr_addr > last_knot) ? last_knot[KNOT_AW-1:0]
                                                 : dr_addr[KNOT_AW-1:0];
            end
            if (vldp_ff) begin
               if (p_c < PIDX_W'(MAX_ORDER)) begin
                  cell_ctl.shift_aj = 1'b1;
                  tail_aj           = push_aj;
               end else begin
                  cell_ctl.shift_dr = 1'b1;
                  tail_dr           = knot_minus_x;
               end
            end
         end
         S_DSTART, S_DWAIT: begin
            if (step_done) begin
               cell_ctl.shift_aj = 1'b1;
               cell_ctl.shift_dr = 1'b1;
               tail_aj           = step_val;
            end
         end
         S_ROT: begin
            cell_ctl.shift_aj = 1'b1;
            cell_ctl.shift_dr = 1'b1;
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   // Tables.
   always_ff @(posedge clock) begin
      if (req_fire && req_action == ACT_WRITE_KNOT) begin
         knot_mem[req_entry_index] <= req_operand_value;
      end
      if (req_fire && req_action == ACT_WRITE_COEF) begin
         coef_mem[req_entry_index] <= req_operand_value;
      end
      knot_rd_ff <= knot_mem[knot_addr];
      coef_rd_ff <= coef_mem[coef_addr];
   end

   // Control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vldp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vldp_ff  <= issue;
         if (state_ff == S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end

      cnt_ff  <= (state_in != state_ff) ? '0 : cnt_ff + CNT_W'(1);
      cntp_ff <= cnt_ff;

      if (req_fire) begin
         act_ff     <= req_action;
         idx_ff     <= req_entry_index;
         v_ff       <= req_operand_value;
         jd_ff      <= req_derivative_order;
         found_ff   <= 1'b0;
         outside_ff <= 1'b0;
         zero_ff    <= 1'b0;
         sat_ff     <= 1'b0;
      end

      if (state_ff == S_EDGE && vldp_ff) begin
         case (cntp_ff[1:0])
            2'd0:    t0_ff <= knot_rd_ff;
            2'd1:    tl_ff <= knot_rd_ff;
            2'd2:    ti_ff <= knot_rd_ff;
            default: tk_ff <= knot_rd_ff;
         endcase
      end

      if (state_ff == S_CHECK) begin
         x_ff <= x_b;
         if (outside_c) outside_ff <= 1'b1;
         if (outside_c || hideriv_c) zero_ff <= 1'b1;
      end

      if (state_ff == S_SCAN) begin
         if (vldp_ff) prev_ff <= knot_rd_ff;
         if (hit) m_ff <= KNOT_AW'(cntp_ff - CNT_W'(1));
         found_ff <= found_in;
         if (cnt_ff == nk && !found_in) begin
            outside_ff <= 1'b1;
            zero_ff    <= 1'b1;
         end
      end

      if (state_ff == S_FETCH) begin
         if (vldp_ff && p_c < PIDX_W'(MAX_ORDER)) begin
            dl_ff[p_c[SLOT_W-1:0]] <= x_minus_knot;
         end
         j_ff  <= ORD_W'(1);
         jj_ff <= SLOT_W'(1);
      end

      if (state_ff == S_MUL1) acc_ff <= prod;
      if (state_ff == S_MUL2) acc_ff <= acc_ff + prod;

      if (step_done) begin
         if (state_ff == S_DWAIT && div_res.sat) sat_ff <= 1'b1;
         if (pass_end) begin
            jj_ff  <= SLOT_W'(1);
            rot_ff <= ORD_W'(MAX_ORDER) - kmj;
         end else begin
            jj_ff <= jj_ff + SLOT_W'(1);
         end
      end

      if (state_ff == S_ROT) begin
         rot_ff <= rot_ff - ORD_W'(1);
         if (rot_ff == ORD_W'(1)) j_ff <= j_ff + ORD_W'(1);
      end

      if (state_ff == S_DONE && out_free) begin
         rsp_value_ff <= zero_ff ? '0 : $signed(aj_q[0]);
         rsp_out_ff   <= outside_ff;
         rsp_sat_ff   <= sat_ff && !zero_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_value    = rsp_value_ff;
   assign rsp_outside_support = rsp_out_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule
`default_nettype wire
